/* design/lnis_pkg.sv */
// ----------------------------------------------------------------------------
// lnis_pkg
// Shared widths, constants and types of the longest non-increasing
// subsequence engine.
// ----------------------------------------------------------------------------
package lnis_pkg;

  localparam int unsigned VALUE_W = 16;
  localparam int unsigned CHAIN_W = 8;
  localparam int unsigned ENTRY_W = VALUE_W + CHAIN_W;

  localparam logic [CHAIN_W-1:0] CHAIN_MAX = {CHAIN_W{1'b1}};

  typedef struct packed {
    logic last;
    logic keep;
  } cls_t;

endpackage

/* design/lnis_if.sv */
// ----------------------------------------------------------------------------
// lnis_if
// Valid/ready channels: sequence elements in, subsequence lengths out.
// ----------------------------------------------------------------------------
interface lnis_in_if;
  import lnis_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface lnis_out_if;
  import lnis_pkg::*;

  logic               valid;
  logic               ready;
  logic [CHAIN_W-1:0] length;
  logic               overflow;

  modport source (output valid, output length, output overflow, input ready);
  modport sink (input valid, input length, input overflow, output ready);
endinterface

/* design/lnis_ram.sv */
// ----------------------------------------------------------------------------
// lnis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lnis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/lnis_fifo.sv */
// ----------------------------------------------------------------------------
// lnis_fifo
// Two-entry queue between the classifying front end and the scan engine.
// ----------------------------------------------------------------------------
module lnis_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? ~wptr_q : wptr_q;
    rptr_d = pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

/* design/lnis_front.sv */
// ----------------------------------------------------------------------------
// lnis_front
// Accepts elements, tracks the fill of the store and tags each beat with its
// store slot, or as dropped once the store is full.
// ----------------------------------------------------------------------------
module lnis_front #(
  parameter int unsigned MAX_ELEMENTS = 128,
  localparam int unsigned ADDR_W = $clog2(MAX_ELEMENTS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lnis_in_if.sink                     in_i,
  input  logic                        full_i,
  output logic                        push_o,
  output lnis_pkg::cls_t              cls_o,
  output logic [ADDR_W-1:0]           idx_o,
  output logic [lnis_pkg::VALUE_W-1:0] value_o
);
  import lnis_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             keep;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign keep       = (cnt_q < CNT_W'(MAX_ELEMENTS));
  assign cls_o.last = in_i.last;
  assign cls_o.keep = keep;
  assign idx_o      = cnt_q[ADDR_W-1:0];
  assign value_o    = in_i.value;

  always_comb begin
    cnt_d = cnt_q;
    if (push_o) begin
      if (in_i.last) begin
        cnt_d = '0;
      end else if (keep) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

/* design/lnis_back.sv */
// ----------------------------------------------------------------------------
// lnis_back
// Scan engine: for each kept element, reads all earlier entries one per
// cycle, keeps the best chain ending at a value not below it, writes the new
// entry and, on the last element, hands the longest chain to the output.
// ----------------------------------------------------------------------------
module lnis_back #(
  parameter int unsigned ADDR_W = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cmd_valid_i,
  output logic                         cmd_pop_o,
  input  lnis_pkg::cls_t               cmd_cls_i,
  input  logic [ADDR_W-1:0]            cmd_idx_i,
  input  logic [lnis_pkg::VALUE_W-1:0] cmd_value_i,
  output logic                         ram_we_o,
  output logic [ADDR_W-1:0]            ram_waddr_o,
  output logic [lnis_pkg::ENTRY_W-1:0] ram_wdata_o,
  output logic [ADDR_W-1:0]            ram_raddr_o,
  input  logic [lnis_pkg::ENTRY_W-1:0] ram_rdata_i,
  lnis_out_if.source                   res_o
);
  import lnis_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic               last_q, last_d;
  logic [CHAIN_W-1:0] max_q, max_d;
  logic               ovf_q, ovf_d;
  logic               out_valid_q, out_valid_d;

  logic [VALUE_W-1:0] val_q, val_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  logic [ADDR_W-1:0]  rd_q, rd_d;
  logic [CHAIN_W-1:0] best_q, best_d;
  logic [CHAIN_W-1:0] out_len_q, out_len_d;
  logic               out_ovf_q, out_ovf_d;

  logic [VALUE_W-1:0] rd_value;
  logic [CHAIN_W-1:0] rd_chain;
  logic [CHAIN_W-1:0] chain_new;

  assign rd_value  = ram_rdata_i[ENTRY_W-1 -: VALUE_W];
  assign rd_chain  = ram_rdata_i[CHAIN_W-1:0];
  assign chain_new = (best_q == CHAIN_MAX) ? best_q : best_q + CHAIN_W'(1);

  assign cmd_pop_o    = (state_q == ST_IDLE) && cmd_valid_i;
  assign ram_waddr_o  = idx_q;
  assign ram_wdata_o  = {val_q, chain_new};
  assign ram_raddr_o  = rd_q;

  assign res_o.valid    = out_valid_q;
  assign res_o.length   = out_len_q;
  assign res_o.overflow = out_ovf_q;

  always_comb begin
    state_d     = state_q;
    last_d      = last_q;
    max_d       = max_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    val_d       = val_q;
    idx_d       = idx_q;
    rd_d        = rd_q;
    best_d      = best_q;
    out_len_d   = out_len_q;
    out_ovf_d   = out_ovf_q;
    ram_we_o    = 1'b0;

    if (res_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          val_d  = cmd_value_i;
          idx_d  = cmd_idx_i;
          last_d = cmd_cls_i.last;
          best_d = '0;
          rd_d   = '0;
          if (!cmd_cls_i.keep) begin
            ovf_d   = 1'b1;
            state_d = cmd_cls_i.last ? ST_EMIT : ST_IDLE;
          end else if (cmd_idx_i == '0) begin
            state_d = ST_WRITE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // data for entry rd_q - 1 arrives this cycle
        if (rd_q != '0 && rd_value >= val_q && rd_chain > best_q) begin
          best_d = rd_chain;
        end
        if (rd_q == idx_q) begin
          state_d = ST_WRITE;
        end else begin
          rd_d = rd_q + ADDR_W'(1);
        end
      end
      ST_WRITE: begin
        ram_we_o = 1'b1;
        if (chain_new > max_q) begin
          max_d = chain_new;
        end
        state_d = last_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_len_d   = max_q;
          out_ovf_d   = ovf_q;
          max_d       = '0;
          ovf_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      max_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      max_q       <= max_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q     <= val_d;
    idx_q     <= idx_d;
    rd_q      <= rd_d;
    best_q    <= best_d;
    out_len_q <= out_len_d;
    out_ovf_q <= out_ovf_d;
  end

endmodule

/* design/longest_non_increasing_subsequence.sv */
// ----------------------------------------------------------------------------
// longest_non_increasing_subsequence
// Streams in a sequence of 16-bit values and returns the length of its
// longest non-increasing subsequence.
//
// in_i carries one element per beat; last marks the end of a sequence.
// res_o carries one beat per sequence: length and an overflow flag, set when
// more than MAX_ELEMENTS elements arrived (extra elements are dropped).
// The front end takes one beat per cycle into a two-entry queue while it has
// room. The scan engine then handles one element at a time: it reads each
// earlier stored entry, one per cycle through the single RAM read port,
// then writes the new entry; a dropped element is only flagged, and the
// last element adds a step that hands over the result.
// The result sits in an output register; while res_o is stalled the engine
// keeps working and stops only when a second result is ready, and the input
// stalls once the queue is full.
// Reset empties the queue and the store fill count; no clearing pass is needed.
// ----------------------------------------------------------------------------
module longest_non_increasing_subsequence #(
  parameter int unsigned MAX_ELEMENTS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lnis_in_if.sink     in_i,
  lnis_out_if.source  res_o
);
  import lnis_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_ELEMENTS);
  localparam int unsigned CMD_W  = $bits(cls_t) + ADDR_W + VALUE_W;

  logic               push;
  cls_t               push_cls;
  logic [ADDR_W-1:0]  push_idx;
  logic [VALUE_W-1:0] push_value;
  logic               q_full;

  logic               cmd_valid;
  logic               cmd_pop;
  logic [CMD_W-1:0]   cmd_data;
  cls_t               cmd_cls;
  logic [ADDR_W-1:0]  cmd_idx;
  logic [VALUE_W-1:0] cmd_value;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  lnis_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (q_full),
    .push_o (push),
    .cls_o  (push_cls),
    .idx_o  (push_idx),
    .value_o(push_value)
  );

  lnis_fifo #(
    .WIDTH(CMD_W)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({push_cls, push_idx, push_value}),
    .full_o (q_full),
    .pop_i  (cmd_pop),
    .valid_o(cmd_valid),
    .data_o (cmd_data)
  );

  assign {cmd_cls, cmd_idx, cmd_value} = cmd_data;

  lnis_back #(
    .ADDR_W(ADDR_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .cmd_cls_i  (cmd_cls),
    .cmd_idx_i  (cmd_idx),
    .cmd_value_i(cmd_value),
    .ram_we_o   (ram_we),
    .ram_waddr_o(ram_waddr),
    .ram_wdata_o(ram_wdata),
    .ram_raddr_o(ram_raddr),
    .ram_rdata_i(ram_rdata),
    .res_o      (res_o)
  );

  lnis_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_ELEMENTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_o.length != '0)
    else $error("result with zero length");

  a_beat_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> cmd_valid)
    else $error("accepted beat missing from queue");

  a_write_not_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && cmd_pop))
    else $error("scan engine pops while writing an entry");

  a_kept_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop && cmd_cls.keep) |-> (32'(cmd_idx) < MAX_ELEMENTS))
    else $error("store slot beyond depth");

endmodule

/* bench/longest_non_increasing_subsequence_tb.sv */
// ----------------------------------------------------------------------------
// longest_non_increasing_subsequence_tb
// Drives sequences of 16-bit values into the subsequence engine and checks
// each returned length and overflow flag against a scoreboard that runs the
// quadratic chain-length recurrence on every stored element. A short
// directed table covers single elements, extreme values, equal runs and
// rising/falling pairs. Random sequences follow, some filling or overrunning
// the store, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module longest_non_increasing_subsequence_tb;
  import lnis_pkg::*;

  localparam int unsigned MAX_ELEMENTS  = 128;
  localparam int unsigned TARGET_ITEMS  = 1200;
  localparam int unsigned CALM_AFTER    = 1020;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES  = 400;
  localparam int unsigned DIRECTED_ROWS = 21;

  typedef enum int unsigned {
    PICK_UNIFORM,
    PICK_FEW,
    PICK_EXTREME,
    PICK_FALLING
  } value_mix_t;

  typedef struct packed {
    logic [CHAIN_W-1:0] length;
    logic               overflow;
  } seq_result_t;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic               last;
    bit                 typed;
    logic [CHAIN_W-1:0] length;
    logic               overflow;
  } stim_row_t;

  // fixed expectations only where the answer is obvious
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{16'h1234, 1'b1, 1'b1, 8'd1, 1'b0},
    '{16'h0000, 1'b1, 1'b1, 8'd1, 1'b0},
    '{16'hFFFF, 1'b1, 1'b1, 8'd1, 1'b0},
    '{16'hFFFF, 1'b0, 1'b0, 8'd0, 1'b0},
    '{16'h0000, 1'b1, 1'b1, 8'd2, 1'b0},
    '{16'h0000, 1'b0, 1'b0, 8'd0, 1'b0},
    '{16'hFFFF, 1'b1, 1'b1, 8'd1, 1'b0},
    '{16'h8000, 1'b0, 1'b0, 8'd0, 1'b0},
    '{16'h7FFF, 1'b1, 1'b1, 8'd2, 1'b0},
    '{16'h0007, 1'b0, 1'b0, 8'd0, 1'b0},
    '{16'h0007, 1'b0, 1'b0, 8'd0, 1'b0},
    '{16'h0007, 1'b1, 1'b1, 8'd3, 1'b0},
    '{16'hAAAA, 1'b0, 1'b0, 8'd0, 1'b0},
    '{16'h5555, 1'b0, 1'b0, 8'd0, 1'b0},
    '{16'hAAAA, 1'b0, 1'b0, 8'd0, 1'b0},
    '{16'h5555, 1'b1, 1'b0, 8'd0, 1'b0},
    '{16'h0001, 1'b0, 1'b0, 8'd0, 1'b0},
    '{16'h0002, 1'b0, 1'b0, 8'd0, 1'b0},
    '{16'h0003, 1'b0, 1'b0, 8'd0, 1'b0},
    '{16'h0002, 1'b0, 1'b0, 8'd0, 1'b0},
    '{16'h0001, 1'b1, 1'b0, 8'd0, 1'b0}
  };

  logic clk_i;
  logic rst_ni;

  lnis_in_if  in_ch ();
  lnis_out_if res_ch ();

  // sideband riding along with each input beat
  bit                 row_typed;
  logic [CHAIN_W-1:0] row_length;
  logic               row_overflow;

  logic [VALUE_W-1:0] stored_value [MAX_ELEMENTS];
  logic [CHAIN_W-1:0] stored_chain [MAX_ELEMENTS];
  int unsigned        stored_count = 0;
  logic               dropped_any  = 1'b0;
  seq_result_t        expected_results [$];

  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  bit          draining    = 1'b0;
  bit          calm        = 1'b0;
  bit          tx_quiet    = 1'b0;
  bit          rx_quiet    = 1'b0;
  logic [4:0]  rx_hold     = '0;

  longest_non_increasing_subsequence #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .res_o (res_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // chain-length recurrence over the elements of the current sequence
  task automatic take_element(input logic [VALUE_W-1:0] v, input logic l, input bit typed,
                              input logic [CHAIN_W-1:0] tl, input logic to);
    int unsigned best;
    seq_result_t r;
    best = 0;
    if (stored_count >= MAX_ELEMENTS) begin
      dropped_any = 1'b1;
    end else begin
      for (int unsigned j = 0; j < stored_count; j++) begin
        if (stored_value[j] >= v && stored_chain[j] > best) best = stored_chain[j];
      end
      best++;
      if (best > CHAIN_MAX) best = CHAIN_MAX;
      stored_value[stored_count] = v;
      stored_chain[stored_count] = best[CHAIN_W-1:0];
      stored_count++;
    end
    if (l) begin
      r.length = '0;
      for (int unsigned i = 0; i < stored_count; i++) begin
        if (stored_chain[i] > r.length) r.length = stored_chain[i];
      end
      r.overflow = dropped_any;
      if (typed) begin
        r.length   = tl;
        r.overflow = to;
      end
      expected_results.push_back(r);
      stored_count = 0;
      dropped_any  = 1'b0;
    end
  endtask

  // scoreboard: result beats first, then the input beat of the same edge
  always @(posedge clk_i) begin
    seq_result_t want;
    if (rst_ni) begin
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: length %0d overflow %0b",
                 res_ch.length, res_ch.overflow);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (res_ch.length !== want.length) begin
            $error("length: expected %0d, actual %0d", want.length, res_ch.length);
            mismatches++;
          end
          if (res_ch.overflow !== want.overflow) begin
            $error("overflow: expected %0b, actual %0b", want.overflow, res_ch.overflow);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        take_element(in_ch.value, in_ch.last, row_typed, row_length, row_overflow);
      end
    end
  end

  // result side backpressure
  always @(posedge clk_i) begin
    if ($urandom_range(0, 399) == 0) rx_quiet <= !rx_quiet;
    if (rx_hold != 0) begin
      res_ch.ready <= 1'b0;
      rx_hold      <= rx_hold - 5'd1;
    end else if (!calm && !rx_quiet && $urandom_range(0, 5) == 0) begin
      res_ch.ready <= 1'b0;
      rx_hold      <= 5'($urandom_range(0, 18));
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !draining) begin
      if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("longest_non_increasing_subsequence_tb: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ready only moves at rising edges, so its value at the falling edge is
  // the one the next rising edge sees
  task automatic push_element(input logic [VALUE_W-1:0] v, input logic l, input bit typed,
                              input logic [CHAIN_W-1:0] tl, input logic to);
    if (!calm && !tx_quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.value  <= v;
    in_ch.last   <= l;
    row_typed    <= typed;
    row_length   <= tl;
    row_overflow <= to;
    @(negedge clk_i);
    while (!in_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned items_sent;
    int unsigned seq_idx;
    int unsigned seq_len;
    int          walk;
    value_mix_t  mix;
    logic [VALUE_W-1:0] v;

    items_sent = 0;
    seq_idx    = 0;
    rst_ni       <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.value  <= '0;
    in_ch.last   <= 1'b0;
    row_typed    <= 1'b0;
    row_length   <= '0;
    row_overflow <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      push_element(directed_rows[k].value, directed_rows[k].last, directed_rows[k].typed,
                   directed_rows[k].length, directed_rows[k].overflow);
      items_sent++;
    end

    while (items_sent < TARGET_ITEMS) begin
      // first sequences sit on the store boundary
      case (seq_idx)
        0: seq_len = MAX_ELEMENTS;
        1: seq_len = MAX_ELEMENTS + 1;
        2: seq_len = MAX_ELEMENTS + 3;
        default: begin
          case ($urandom_range(0, 19))
            0:       seq_len = $urandom_range(MAX_ELEMENTS - 1, MAX_ELEMENTS + 3);
            1, 2, 3: seq_len = $urandom_range(1, 3);
            default: seq_len = $urandom_range(2, 30);
          endcase
        end
      endcase
      mix      = value_mix_t'($urandom_range(0, 3));
      tx_quiet = ($urandom_range(0, 2) == 0);
      walk     = int'($urandom_range(30000, 65535));
      for (int unsigned i = 0; i < seq_len; i++) begin
        case (mix)
          PICK_UNIFORM: v = 16'($urandom_range(0, 65535));
          PICK_FEW:     v = 16'($urandom_range(0, 3));
          PICK_EXTREME: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          default: begin
            walk = walk - int'($urandom_range(0, 600));
            if ($urandom_range(0, 4) == 0) walk = walk + int'($urandom_range(0, 1500));
            if (walk < 0) walk = 0;
            if (walk > 65535) walk = 65535;
            v = walk[VALUE_W-1:0];
          end
        endcase
        push_element(v, i == seq_len - 1, 1'b0, '0, 1'b0);
        items_sent++;
        if (items_sent == CALM_AFTER) calm <= 1'b1;
      end
      seq_idx++;
    end
    in_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    draining <= 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("longest_non_increasing_subsequence_tb: PASS");
    end else begin
      $display("longest_non_increasing_subsequence_tb: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/lnis_pkg.sv
design/lnis_if.sv
design/lnis_ram.sv
design/lnis_fifo.sv
design/lnis_front.sv
design/lnis_back.sv
design/longest_non_increasing_subsequence.sv
bench/longest_non_increasing_subsequence_tb.sv
